// ===== design/bpfa_pkg.sv =====
package bpfa_pkg;

   localparam int CNT_W = 17;
   localparam int PAGE_W = 16;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic [CNT_W-1:0] TOTAL_RESET = 17'd65536;

   localparam logic [2:0] ACT_REQUEST = 3'd0;
   localparam logic [2:0] ACT_FREE = 3'd1;
   localparam logic [2:0] ACT_LOCK = 3'd2;
   localparam logic [2:0] ACT_RESERVE = 3'd3;
   localparam logic [2:0] ACT_UNRESERVE = 3'd4;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_SAME = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   typedef struct packed {
      logic [2:0] action;
      logic [PAGE_W-1:0] page_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [PAGE_W-1:0] granted_page;
      logic [CNT_W-1:0] free_pages;
      logic [CNT_W-1:0] used_pages;
      logic [CNT_W-1:0] reserved_pages;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic mul;
      logic div;
      logic read;
      logic check;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic skip;
      logic more;
      logic rsp_free;
   } sts_type;

endpackage

// ===== design/bitmap_page_frame_allocator.sv =====
// Bitmap page frame allocator: one bit per page in a map RAM of MAP_WORD_BITS-bit words.
// After reset the block clears the map, one word a cycle, all ceil(PAGE_COUNT / MAP_WORD_BITS)
// words (1024 with the default parameters); req_stall stays high meanwhile, csr writes are
// taken at any time. total_pages may only be written while no request is in flight. A free,
// lock, reserve or unreserve goes through the split of the page number, one map read, a write
// back if the bit changes and the response load before the next acceptance. A page request
// scans map words from the search hint: each word costs one registered RAM read and one
// check. Out-of-range requests, unknown actions and a search hint at the limit skip the map.
// One response register decouples rsp_stall from the request side.
module bitmap_page_frame_allocator #(
   parameter int PAGE_COUNT = 65536,
   parameter int MAP_WORD_BITS = 64
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input bpfa_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output bpfa_pkg::rsp_type rsp_data,
   input logic csr_we,
   input logic [bpfa_pkg::CNT_W-1:0] csr_wdata
);

   bpfa_pkg::cmd_type cmd;
   bpfa_pkg::sts_type sts;

   bpfa_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts(sts),
      .cmd(cmd)
   );

   bpfa_datapath #(
      .PAGE_COUNT(PAGE_COUNT),
      .MAP_WORD_BITS(MAP_WORD_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_data(req_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule

// ===== design/bpfa_ram.sv =====
module bpfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input logic clock,
   input logic we,
   input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input logic [WIDTH-1:0] wdata,
   input logic re,
   input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/bpfa_ctrl.sv =====
module bpfa_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input bpfa_pkg::sts_type sts,
   output bpfa_pkg::cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE = 7'b0000010,
      ST_MUL = 7'b0000100,
      ST_DIV = 7'b0001000,
      ST_READ = 7'b0010000,
      ST_CHECK = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            state_in = sts.skip ? ST_FINISH : ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in = sts.more ? ST_READ : ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== design/bpfa_datapath.sv =====
module bpfa_datapath #(
   parameter int PAGE_COUNT = 65536,
   parameter int MAP_WORD_BITS = 64
) (
   input logic clock,
   input logic reset,
   input bpfa_pkg::cmd_type cmd,
   output bpfa_pkg::sts_type sts,
   input bpfa_pkg::req_type req_data,
   input logic csr_we,
   input logic [bpfa_pkg::CNT_W-1:0] csr_wdata,
   output logic rsp_valid,
   input logic rsp_stall,
   output bpfa_pkg::rsp_type rsp_data
);

   localparam int CNT_W = bpfa_pkg::CNT_W;
   localparam int MAP_WORDS = (PAGE_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int ADDR_W = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
   localparam int OFF_W = $clog2(MAP_WORD_BITS);
   localparam int RECIP_SHIFT = CNT_W + 7;
   localparam int RECIP = (1 << RECIP_SHIFT) / MAP_WORD_BITS;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W = CNT_W + RECIP_W;
   localparam logic [CNT_W-1:0] LIMIT_CAP =
      (PAGE_COUNT > int'(bpfa_pkg::CNT_MAX)) ? bpfa_pkg::CNT_MAX : CNT_W'(PAGE_COUNT);
   localparam logic [CNT_W-1:0] WORD_C = CNT_W'(MAP_WORD_BITS);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAP_WORDS - 1);

   // control state
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] hint_ff, hint_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] rsvd_ff, rsvd_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in;

   // payload
   logic [2:0] op_ff, op_in;
   logic [bpfa_pkg::PAGE_W-1:0] page_ff, page_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0] word_ff, word_in;
   logic [CNT_W-1:0] base_ff, base_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic first_ff, first_in;
   logic [1:0] status_ff, status_in;
   logic [bpfa_pkg::PAGE_W-1:0] granted_ff, granted_in;
   bpfa_pkg::rsp_type rsp_ff, rsp_in;

   logic [CNT_W-1:0] limit;
   logic [CNT_W-1:0] src;
   logic [CNT_W-1:0] page17;
   logic is_req;
   logic known;
   logic set_op;

   logic [CNT_W-1:0] q_est;
   logic [CNT_W-1:0] r_est;
   logic fix;
   logic [CNT_W-1:0] q_fix;
   logic [CNT_W-1:0] r_fix;

   logic [MAP_WORD_BITS-1:0] rdata;
   logic [MAP_WORD_BITS-1:0] cand;
   logic [MAP_WORD_BITS-1:0] word_wdata;
   logic [CNT_W-1:0] rem;
   logic [OFF_W-1:0] off_lo;
   logic [OFF_W-1:0] sel;
   logic found;
   logic cur_bit;
   logic change;
   logic [OFF_W-1:0] wr_idx;
   logic [CNT_W-1:0] grant_page;

   logic [CNT_W:0] taken;
   logic [CNT_W-1:0] free_pages;

   logic ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [MAP_WORD_BITS-1:0] ram_wdata;

   function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
      return (c == bpfa_pkg::CNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] c);
      return (c == '0) ? c : c - 1'b1;
   endfunction

   assign limit = (total_ff > LIMIT_CAP) ? LIMIT_CAP : total_ff;
   assign is_req = (op_ff == bpfa_pkg::ACT_REQUEST);
   assign known = (op_ff <= bpfa_pkg::ACT_UNRESERVE);
   assign set_op = (op_ff == bpfa_pkg::ACT_LOCK) || (op_ff == bpfa_pkg::ACT_RESERVE);
   assign page17 = CNT_W'(page_ff);
   assign src = is_req ? hint_ff : page17;

   // split the page number into map word and bit offset
   assign q_est = CNT_W'(prod_ff >> RECIP_SHIFT);
   assign r_est = src - CNT_W'(q_est * WORD_C);
   assign fix = (r_est >= WORD_C);
   assign q_fix = fix ? q_est + 1'b1 : q_est;
   assign r_fix = fix ? r_est - WORD_C : r_est;

   assign sts.skip = is_req ? (hint_ff >= limit) : (!known || (page17 >= limit));

   // scan one map word
   assign rem = limit - base_ff;
   assign off_lo = first_ff ? off_ff : '0;

   always_comb begin
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         cand[b] = !rdata[b] && (OFF_W'(b) >= off_lo) && (rem > CNT_W'(b));
      end
   end

   always_comb begin
      sel = '0;
      for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            sel = OFF_W'(b);
         end
      end
   end

   assign found = |cand;
   assign sts.more = is_req && !found && (rem > WORD_C);
   assign cur_bit = rdata[off_ff];
   assign change = set_op ? !cur_bit : cur_bit;
   assign wr_idx = is_req ? sel : off_ff;
   assign grant_page = base_ff + CNT_W'(sel);

   always_comb begin
      word_wdata = rdata;
      word_wdata[wr_idx] = is_req ? 1'b1 : set_op;
   end

   assign ram_we = cmd.clear || (cmd.check && (is_req ? found : change));
   assign ram_waddr = cmd.clear ? clr_ff : ADDR_W'(word_ff);
   assign ram_wdata = cmd.clear ? '0 : word_wdata;

   bpfa_ram #(
      .WIDTH(MAP_WORD_BITS),
      .DEPTH(MAP_WORDS)
   ) u_map (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(cmd.read),
      .raddr(ADDR_W'(word_ff)),
      .rdata(rdata)
   );

   assign sts.clear_last = (clr_ff == CLR_LAST);
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign taken = {1'b0, used_ff} + {1'b0, rsvd_ff};
   assign free_pages = ({1'b0, limit} > taken) ? CNT_W'({1'b0, limit} - taken) : '0;

   always_comb begin
      total_in = csr_we ? csr_wdata : total_ff;
      hint_in = hint_ff;
      used_in = used_ff;
      rsvd_in = rsvd_ff;
      clr_in = clr_ff;
      op_in = op_ff;
      page_in = page_ff;
      prod_in = prod_ff;
      word_in = word_ff;
      base_in = base_ff;
      off_in = off_ff;
      first_in = first_ff;
      status_in = status_ff;
      granted_in = granted_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.clear) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.load) begin
         op_in = req_data.action;
         page_in = req_data.page_index;
         granted_in = '0;
      end
      if (cmd.mul) begin
         prod_in = PROD_W'(src) * PROD_W'(RECIP);
      end
      if (cmd.div) begin
         word_in = q_fix;
         off_in = OFF_W'(r_fix);
         base_in = src - r_fix;
         first_in = 1'b1;
         status_in = bpfa_pkg::STATUS_DONE;
         if (sts.skip) begin
            if (is_req) begin
               status_in = bpfa_pkg::STATUS_EMPTY;
               hint_in = limit;
            end else if (known) begin
               status_in = bpfa_pkg::STATUS_RANGE;
            end
         end
      end
      if (cmd.check) begin
         if (is_req) begin
            if (found) begin
               used_in = count_up(used_ff);
               hint_in = grant_page;
               granted_in = bpfa_pkg::PAGE_W'(grant_page);
               status_in = bpfa_pkg::STATUS_DONE;
            end else if (sts.more) begin
               // advance to the next map word
               word_in = word_ff + 1'b1;
               base_in = base_ff + WORD_C;
               first_in = 1'b0;
            end else begin
               status_in = bpfa_pkg::STATUS_EMPTY;
               hint_in = limit;
            end
         end else if (!change) begin
            status_in = bpfa_pkg::STATUS_SAME;
         end else begin
            case (op_ff)
               bpfa_pkg::ACT_FREE: used_in = count_down(used_ff);
               bpfa_pkg::ACT_LOCK: used_in = count_up(used_ff);
               bpfa_pkg::ACT_RESERVE: rsvd_in = count_up(rsvd_ff);
               bpfa_pkg::ACT_UNRESERVE: rsvd_in = count_down(rsvd_ff);
               default: used_in = used_ff;
            endcase
            // pull the hint down on a release
            if (!set_op && (hint_ff > page17)) begin
               hint_in = page17;
            end
         end
      end
      if (cmd.finish) begin
         rsp_in.status = status_ff;
         rsp_in.granted_page = granted_ff;
         rsp_in.free_pages = free_pages;
         rsp_in.used_pages = used_ff;
         rsp_in.reserved_pages = rsvd_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= bpfa_pkg::TOTAL_RESET;
         hint_ff <= '0;
         used_ff <= '0;
         rsvd_ff <= '0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         hint_ff <= hint_in;
         used_ff <= used_in;
         rsvd_ff <= rsvd_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      page_ff <= page_in;
      prod_ff <= prod_in;
      word_ff <= word_in;
      base_ff <= base_in;
      off_ff <= off_in;
      first_ff <= first_in;
      status_ff <= status_in;
      granted_ff <= granted_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
